// ----- hw/rtl/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// Request timeout tracker package
// Shared types and constants for the front queue and the table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int ID_W    = 32;
  localparam int TMO_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int QDEPTH  = 2;

  localparam logic [1:0] CMD_NEW  = 2'd0;
  localparam logic [1:0] CMD_RESP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  typedef enum logic [1:0] {
    OP_NEW,
    OP_RESP,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    KIND_ACCEPT    = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_DELIVER   = 3'd2,
    KIND_UNMATCHED = 3'd3,
    KIND_RETX      = 3'd4,
    KIND_TIMEOUT   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } st_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  req_id;
    logic [TMO_W-1:0] timeout;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id_out;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  req_id;
    logic [TMO_W-1:0] timeout;
  } q_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rtt_front.sv -----
// ----------------------------------------------------------------------------
// Request timeout tracker front end
// Accepts commands, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_front
  import rtt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output q_item_t       q_item,
  input  wire logic     q_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_item_t          q_mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             do_pop;
  logic             known;
  q_item_t          dec_item;

  assign in_stall = (cnt_r == CNT_W'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // The unused command code is taken and dropped here.
  always_comb begin
    known            = 1'b1;
    dec_item.op      = OP_NEW;
    dec_item.req_id  = in_data.req_id;
    dec_item.timeout = in_data.timeout;
    unique case (in_data.cmd)
      CMD_NEW:  dec_item.op = OP_NEW;
      CMD_RESP: dec_item.op = OP_RESP;
      CMD_TICK: dec_item.op = OP_TICK;
      default:  known = 1'b0;
    endcase
  end

  assign push   = in_valid && !in_stall && known;
  assign do_pop = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rtt_back.sv -----
// ----------------------------------------------------------------------------
// Request timeout tracker back end
// Holds the table; a response or tick walks a slot per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_back
  import rtt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  wire q_item_t   q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [ENTRIES-1:0] valid_r;
  logic [ID_W-1:0]    id_r   [ENTRIES];
  logic [TMO_W-1:0]   lim_r  [ENTRIES];
  logic [TMO_W-1:0]   ticks_r[ENTRIES];

  st_t              state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  op_t              cur_op_r;
  logic [ID_W-1:0]  cur_id_r;
  logic             pend_valid_r, pend_valid_nxt;
  out_item_t        pend_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  logic             e_valid;
  logic [ID_W-1:0]  e_id;
  logic [TMO_W-1:0] e_ticks;
  logic [TMO_W-1:0] tick_inc;
  logic             below;
  logic             hit;
  out_item_t        hit_item;
  logic             out_free;
  logic             walk_go;
  logic             walk_end;
  logic             flush_needs_out;
  logic [IDX_W-1:0] free_idx;
  logic             free_found;

  logic             out_load;
  out_item_t        out_load_item;
  logic             pend_set;
  logic             pend_clr;
  logic             cur_load;
  logic             wr_new;
  logic             wr_walk;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entry under the walk pointer.
  assign e_valid  = valid_r[idx_r];
  assign e_id     = id_r[idx_r];
  assign e_ticks  = ticks_r[idx_r];
  assign tick_inc = e_ticks + 1'b1;
  assign below    = (e_ticks < lim_r[idx_r]);

  always_comb begin
    hit_item.slot   = SLOT_W'(idx_r);
    hit_item.id_out = e_id;
    hit_item.last   = 1'b0;
    if (cur_op_r == OP_RESP) begin
      hit           = e_valid && (e_id == cur_id_r);
      hit_item.kind = KIND_DELIVER;
    end else begin
      hit           = e_valid && (!below || !tick_inc[0]);
      hit_item.kind = below ? KIND_RETX : KIND_TIMEOUT;
    end
  end

  // Lowest free slot.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign out_free        = !out_valid_r || !out_stall;
  assign walk_go         = (state_r == ST_WALK) && (!hit || !pend_valid_r || out_free);
  assign walk_end        = (idx_r == IDX_W'(ENTRIES - 1));
  assign flush_needs_out = pend_valid_r || (cur_op_r == OP_RESP);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op != OP_NEW) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_go && walk_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!flush_needs_out || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controls.
  always_comb begin
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_load_item = pend_r;
    pend_set      = 1'b0;
    pend_clr      = 1'b0;
    cur_load      = 1'b0;
    wr_new        = 1'b0;
    wr_walk       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_NEW) begin
            if (out_free) begin
              q_pop                = 1'b1;
              out_load             = 1'b1;
              wr_new               = free_found;
              out_load_item.kind   = free_found ? KIND_ACCEPT : KIND_FULL;
              out_load_item.slot   = free_found ? SLOT_W'(free_idx) : '0;
              out_load_item.id_out = q_item.req_id;
              out_load_item.last   = 1'b1;
            end
          end else begin
            q_pop    = 1'b1;
            cur_load = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          wr_walk = 1'b1;
          if (hit) begin
            pend_set           = 1'b1;
            out_load           = pend_valid_r;
            out_load_item.last = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_valid_r) begin
            out_load           = 1'b1;
            out_load_item.last = 1'b1;
            pend_clr           = 1'b1;
          end else if (cur_op_r == OP_RESP) begin
            out_load             = 1'b1;
            out_load_item.kind   = KIND_UNMATCHED;
            out_load_item.slot   = '0;
            out_load_item.id_out = cur_id_r;
            out_load_item.last   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cur_load) begin
      idx_nxt = '0;
    end else if (walk_go) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (pend_set) begin
      pend_valid_nxt = 1'b1;
    end else if (pend_clr) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur_op_r <= q_item.op;
      cur_id_r <= q_item.req_id;
    end
    if (pend_set) begin
      pend_r <= hit_item;
    end
    if (out_load) begin
      out_data_r <= out_load_item;
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_new) begin
      valid_r[free_idx] <= 1'b1;
    end else if (wr_walk && hit && (cur_op_r == OP_RESP || !below)) begin
      valid_r[idx_r] <= 1'b0;
    end
  end

  // Slot contents.
  always_ff @(posedge clk) begin
    if (wr_new) begin
      id_r[free_idx]    <= q_item.req_id;
      lim_r[free_idx]   <= q_item.timeout;
      ticks_r[free_idx] <= '0;
    end else if (wr_walk && cur_op_r == OP_TICK && e_valid && below) begin
      ticks_r[idx_r] <= tick_inc;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/request_timeout_tracker_core.sv -----
// New request: its single result is registered and appears in the cycle after it leaves the queue.
// A response or a tick walks all 16 slots, one per cycle unless a result waits on a blocked output.
// Throughput: one new request per cycle while the output is free; each walk ends before the next pop.
// Reset: rst_n is synchronous and active low; it empties the queue and frees every slot.
// ----------------------------------------------------------------------------
// Request timeout tracker core
// Tracks up to sixteen outstanding requests with per-request tick limits,
// matching responses, retransmission requests and timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module request_timeout_tracker_core
  import rtt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  // Command channel.
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  // Result channel.
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // The front end decodes each command transfer and parks it in a two-entry
  // queue, so new commands are taken while the table walk is still busy.
  // The unused command code is accepted and dropped without a result.
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  rtt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back end owns the slot table. A new request goes straight to the
  // lowest free slot. A response or tick visits the slots in ascending
  // order; each result waits in a pending register until the next one, so
  // that the final result of a command can be flagged as last when the walk
  // ends. Results leave through an output register, and the walk pauses
  // when a result must enter that register while it is blocked.
  rtt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Request timeout tracker core testbench
// Sends new requests, responses, ticks and unused command codes to the core.
// A slot table model predicts every result, and each result transfer is
// checked in order against that prediction under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import rtt_pkg::*;

// The model keeps its own copy of the slot table and the queue of results that
// the core still owes.
class slot_table_model;

  bit               live[ENTRIES];
  logic [ID_W-1:0]  held_id[ENTRIES];
  logic [TMO_W-1:0] limit_of[ENTRIES];
  logic [TMO_W-1:0] count_of[ENTRIES];

  out_item_t due_results[$];
  int        errors;
  int        commands_seen;
  int        results_seen;
  int        kind_count[6];

  function new();
    foreach (live[i]) live[i] = 1'b0;
    errors        = 0;
    commands_seen = 0;
    results_seen  = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
  endfunction

  function int active_count();
    int n;
    n = 0;
    foreach (live[i]) if (live[i]) n++;
    return n;
  endfunction

  // Returns the id of a randomly chosen active slot. The caller makes sure
  // that at least one slot is active.
  function logic [ID_W-1:0] pick_active_id();
    int busy[$];
    foreach (live[i]) if (live[i]) busy.insert(busy.size(), i);
    return held_id[busy[$urandom_range(busy.size() - 1)]];
  endfunction

  function void note_command(in_item_t cmd_in);
    out_item_t batch[$];
    out_item_t r;
    bit        placed;
    commands_seen++;
    placed = 1'b0;
    r.last = 1'b0;
    case (cmd_in.cmd)
      CMD_NEW: begin
        // The lowest free slot takes the request.
        for (int i = 0; i < ENTRIES && !placed; i++) begin
          if (!live[i]) begin
            live[i]     = 1'b1;
            held_id[i]  = cmd_in.req_id;
            limit_of[i] = cmd_in.timeout;
            count_of[i] = '0;
            r.kind      = KIND_ACCEPT;
            r.slot      = SLOT_W'(i);
            r.id_out    = cmd_in.req_id;
            batch.insert(batch.size(), r);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          r.kind   = KIND_FULL;
          r.slot   = '0;
          r.id_out = cmd_in.req_id;
          batch.insert(batch.size(), r);
        end
      end
      CMD_RESP: begin
        // Every active slot with a matching id is delivered and freed.
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i] && held_id[i] == cmd_in.req_id) begin
            live[i]  = 1'b0;
            r.kind   = KIND_DELIVER;
            r.slot   = SLOT_W'(i);
            r.id_out = cmd_in.req_id;
            batch.insert(batch.size(), r);
          end
        end
        if (batch.size() == 0) begin
          r.kind   = KIND_UNMATCHED;
          r.slot   = '0;
          r.id_out = cmd_in.req_id;
          batch.insert(batch.size(), r);
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i]) begin
            r.slot   = SLOT_W'(i);
            r.id_out = held_id[i];
            if (count_of[i] < limit_of[i]) begin
              count_of[i] = count_of[i] + 1'b1;
              if (!count_of[i][0]) begin
                r.kind = KIND_RETX;
                batch.insert(batch.size(), r);
              end
            end else begin
              live[i] = 1'b0;
              r.kind  = KIND_TIMEOUT;
              batch.insert(batch.size(), r);
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[j]) due_results.insert(due_results.size(), batch[j]);
  endfunction

  function void report_field(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (int'(got.kind) < 6) kind_count[int'(got.kind)]++;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d slot %0d id %0h last %0d",
               $time, got.kind, got.slot, got.id_out, got.last);
      errors++;
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind) report_field("kind", ID_W'(want.kind), ID_W'(got.kind));
    if (got.slot !== want.slot) report_field("slot", ID_W'(want.slot), ID_W'(got.slot));
    if (got.id_out !== want.id_out) report_field("id_out", want.id_out, got.id_out);
    if (got.last !== want.last) report_field("last", ID_W'(want.last), ID_W'(got.last));
  endfunction

endclass

module tb;

  // The unused command code must leave the core untouched.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Number of random commands that the core acts on.
  localparam int RANDOM_COMMANDS = 250;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // When steady is set, neither side idles, so back-to-back transfers are
  // exercised over a long stretch of the run.
  bit steady = 1'b0;

  slot_table_model table_model;

  request_timeout_tracker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The result side stalls at random about six percent of the time. All
  // stimulus changes on the falling edge, so the core sees stable inputs at
  // every rising edge.
  always @(negedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(99) < 6);
  end

  // A result transfer happens at a rising edge with out_valid high and
  // out_stall low. The values read here are those from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      table_model.check_result(out_data);
    end
  end

  // Drives one command and holds it until the core takes it. The driver itself
  // notes the transfer in the model, so the model is up to date before the
  // next command is chosen from its contents.
  task automatic send_cmd(logic [1:0] cmd, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo);
    in_item_t item;
    item.cmd     = cmd;
    item.req_id  = id;
    item.timeout = tmo;
    while (!steady && $urandom_range(99) < 6) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    table_model.note_command(item);
  endtask

  // Fills the table with extreme and duplicate ids, overflows it, and then
  // walks through the response and tick cases.
  task automatic run_directed();
    logic [ID_W-1:0]  id;
    logic [TMO_W-1:0] tmo;
    // A tick on an empty table gives no result.
    send_cmd(CMD_TICK, '0, '0);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i == 0) begin
        id  = '0;
        tmo = '0;
      end else if (i == 1) begin
        id  = '1;
        tmo = '1;
      end else begin
        // Slots two and three carry the same id.
        id  = (i < 4) ? 32'h5A5A_5A5A : 32'hC0DE_0000 + i;
        tmo = TMO_W'(i % 4);
      end
      send_cmd(CMD_NEW, id, tmo);
    end
    // The table is full now.
    send_cmd(CMD_NEW, 32'hA5A5_A5A5, 16'h0003);
    send_cmd(CMD_UNUSED, '1, '1);
    // Slots with a zero limit time out on the first tick.
    send_cmd(CMD_TICK, '0, '0);
    // One response frees both slots that hold the duplicated id.
    send_cmd(CMD_RESP, 32'h5A5A_5A5A, '0);
    send_cmd(CMD_RESP, 32'h0BAD_0000, '0);
    send_cmd(CMD_TICK, '0, '0);
    send_cmd(CMD_TICK, '0, '0);
  endtask

  // Random commands: mostly new requests, responses to held ids and ticks,
  // with some stray responses and a few unused command codes. Short limits
  // dominate so that retransmits and timeouts are frequent, and a small id
  // pool produces duplicates.
  task automatic run_random();
    int               acted;
    int               roll;
    logic [ID_W-1:0]  id;
    logic [TMO_W-1:0] tmo;
    acted = 0;
    while (acted < RANDOM_COMMANDS) begin
      steady = (acted >= 100 && acted < 180);
      roll   = $urandom_range(99);
      id     = $urandom;
      tmo    = ($urandom_range(9) == 0) ? TMO_W'($urandom) : TMO_W'($urandom_range(6));
      if (roll < 3) begin
        send_cmd(CMD_UNUSED, id, TMO_W'($urandom));
      end else begin
        if (roll < 40) begin
          if ($urandom_range(3) == 0) id = 32'hD00D_0000 | $urandom_range(3);
          send_cmd(CMD_NEW, id, tmo);
        end else if (roll < 70) begin
          if (table_model.active_count() != 0 && $urandom_range(4) != 0) begin
            id = table_model.pick_active_id();
          end
          send_cmd(CMD_RESP, id, tmo);
        end else begin
          send_cmd(CMD_TICK, id, tmo);
        end
        acted++;
      end
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  initial begin
    table_model = new();
    // Synchronous reset, released on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random();

    // Wait for every outstanding result, then allow a full table walk more
    // so that any surplus result would still be caught.
    while (table_model.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d command transfers and %0d result transfers.",
             table_model.commands_seen, table_model.results_seen);
    $display("By kind: %0d accept, %0d full, %0d deliver, %0d unmatched, %0d retx, %0d timeout.",
             table_model.kind_count[KIND_ACCEPT], table_model.kind_count[KIND_FULL],
             table_model.kind_count[KIND_DELIVER], table_model.kind_count[KIND_UNMATCHED],
             table_model.kind_count[KIND_RETX], table_model.kind_count[KIND_TIMEOUT]);
    if (table_model.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a correct run needs far less than this.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_front.sv
hw/rtl/rtt_back.sv
hw/rtl/request_timeout_tracker_core.sv
bench/tb.sv
